[sv/can_network_management_fsm_assert.svh]
// Assertion macros shared by the CAN network management checker.
`ifndef CAN_NETWORK_MANAGEMENT_FSM_ASSERT_SVH
`define CAN_NETWORK_MANAGEMENT_FSM_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CNM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CNM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/cnm_pkg.sv]
// Types, codes and entry functions for the CAN network management block.
package cnm_pkg;

	localparam int CNT_W = 16;

	localparam logic [2:0] ST_BUS_SLEEP   = 3'd0;
	localparam logic [2:0] ST_PREP_SLEEP  = 3'd1;
	localparam logic [2:0] ST_READY_SLEEP = 3'd2;
	localparam logic [2:0] ST_NORMAL      = 3'd3;
	localparam logic [2:0] ST_REPEAT      = 3'd4;

	localparam logic [1:0] MODE_BUS_SLEEP  = 2'd0;
	localparam logic [1:0] MODE_PREP_SLEEP = 2'd1;
	localparam logic [1:0] MODE_NETWORK    = 2'd2;

	localparam logic [2:0] KIND_TICK    = 3'd0;
	localparam logic [2:0] KIND_REQUEST = 3'd1;
	localparam logic [2:0] KIND_RELEASE = 3'd2;
	localparam logic [2:0] KIND_FRAME   = 3'd3;
	localparam logic [2:0] KIND_INIT    = 3'd4;
	localparam logic [2:0] KIND_DEINIT  = 3'd5;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_NO_INIT    = 2'd1;
	localparam logic [1:0] STAT_BAD_HANDLE = 2'd2;

	localparam logic [1:0] CFG_MSG_CYCLE  = 2'd0;
	localparam logic [1:0] CFG_REPEAT_MSG = 2'd1;
	localparam logic [1:0] CFG_NM_TIMEOUT = 2'd2;
	localparam logic [1:0] CFG_WAIT_SLEEP = 2'd3;

	localparam logic [CNT_W-1:0] RST_MSG_CYCLE  = 16'd10;
	localparam logic [CNT_W-1:0] RST_REPEAT_MSG = 16'd150;
	localparam logic [CNT_W-1:0] RST_NM_TIMEOUT = 16'd200;
	localparam logic [CNT_W-1:0] RST_WAIT_SLEEP = 16'd200;

	localparam logic [7:0] CBV_REPEAT_REQ    = 8'h01;
	localparam logic [7:0] CBV_ACTIVE_WAKEUP = 8'h10;

	typedef struct packed {
		logic [CNT_W-1:0] msg_cycle;
		logic [CNT_W-1:0] repeat_msg;
		logic [CNT_W-1:0] nm_timeout;
		logic [CNT_W-1:0] wait_sleep;
	} cfg_t;

	typedef struct packed {
		logic             init;
		logic [2:0]       fsm;
		logic             req;
		logic [CNT_W-1:0] tmo;
		logic [CNT_W-1:0] rpt;
		logic [CNT_W-1:0] slp;
		logic [CNT_W-1:0] cyc;
		logic             tx;
		logic [7:0]       cbv;
	} nm_st_t;

	// Last member sits in the lowest bits, so nm_state is bit 0 upward.
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] frame_cbv;
		logic       send_frame;
		logic       mode_report;
		logic [1:0] nm_mode;
		logic [2:0] nm_state;
	} res_t;

	localparam int RES_W  = $bits(res_t);
	localparam int DATA_W = ((RES_W + 7) / 8) * 8;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic nm_st_t go_repeat(input nm_st_t s);
		nm_st_t r;
		r = s;
		r.fsm = ST_REPEAT;
		r.rpt = '0;
		r.tmo = '0;
		r.cyc = '0;
		r.tx  = 1'b1;
		r.cbv = s.cbv | CBV_REPEAT_REQ;
		return r;
	endfunction

	function automatic nm_st_t go_normal(input nm_st_t s);
		nm_st_t r;
		r = s;
		r.fsm = ST_NORMAL;
		r.tmo = '0;
		r.tx  = 1'b1;
		r.cbv = s.cbv & ~CBV_REPEAT_REQ;
		return r;
	endfunction

	function automatic nm_st_t go_ready(input nm_st_t s);
		nm_st_t r;
		r = s;
		r.fsm = ST_READY_SLEEP;
		r.tmo = '0;
		r.tx  = 1'b0;
		return r;
	endfunction

	function automatic nm_st_t go_prep(input nm_st_t s);
		nm_st_t r;
		r = s;
		r.fsm = ST_PREP_SLEEP;
		r.slp = '0;
		r.tx  = 1'b0;
		return r;
	endfunction

	function automatic nm_st_t go_bus_sleep(input nm_st_t s);
		nm_st_t r;
		r = s;
		r.fsm = ST_BUS_SLEEP;
		r.tx  = 1'b0;
		return r;
	endfunction

endpackage

[sv/cnm_cfg.sv]
// Timing configuration registers of the CAN network management block.
module cnm_cfg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_idx,
	input  logic [cnm_pkg::CNT_W-1:0] cfg_wdata,
	output cnm_pkg::cfg_t            cfg
);

	cnm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{
				msg_cycle:  cnm_pkg::RST_MSG_CYCLE,
				repeat_msg: cnm_pkg::RST_REPEAT_MSG,
				nm_timeout: cnm_pkg::RST_NM_TIMEOUT,
				wait_sleep: cnm_pkg::RST_WAIT_SLEEP
			};
		end else if (cfg_we) begin
			unique case (cfg_idx)
				cnm_pkg::CFG_MSG_CYCLE:  cfg_q.msg_cycle  <= cfg_wdata;
				cnm_pkg::CFG_REPEAT_MSG: cfg_q.repeat_msg <= cfg_wdata;
				cnm_pkg::CFG_NM_TIMEOUT: cfg_q.nm_timeout <= cfg_wdata;
				cnm_pkg::CFG_WAIT_SLEEP: cfg_q.wait_sleep <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/cnm_step.sv]
// Next-state and result logic for one network management event.
module cnm_step (
	input  cnm_pkg::nm_st_t st,
	input  cnm_pkg::cfg_t   cfg,
	input  logic [2:0]      kind,
	input  logic [7:0]      net_handle,
	output cnm_pkg::nm_st_t st_nxt,
	output cnm_pkg::res_t   res
);

	cnm_pkg::nm_st_t             n;
	logic [cnm_pkg::CNT_W-1:0]   cyc_inc;
	logic [cnm_pkg::CNT_W-1:0]   tmo_inc;
	logic [cnm_pkg::CNT_W-1:0]   rpt_inc;
	logic [cnm_pkg::CNT_W-1:0]   slp_inc;
	logic                        cyc_hit;
	logic                        rep;
	logic                        sent;
	logic [1:0]                  status;
	logic                        asleep;

	assign cyc_inc = cnm_pkg::sat_inc(st.cyc);
	assign tmo_inc = cnm_pkg::sat_inc(st.tmo);
	assign rpt_inc = cnm_pkg::sat_inc(st.rpt);
	assign slp_inc = cnm_pkg::sat_inc(st.slp);
	assign cyc_hit = (cyc_inc >= cfg.msg_cycle);
	assign asleep  = (st.fsm == cnm_pkg::ST_BUS_SLEEP) || (st.fsm == cnm_pkg::ST_PREP_SLEEP);

	always_comb begin
		n      = st;
		rep    = 1'b0;
		sent   = 1'b0;
		status = cnm_pkg::STAT_OK;
		if (kind == cnm_pkg::KIND_INIT) begin
			n      = '0;
			n.init = 1'b1;
			n.fsm  = cnm_pkg::ST_BUS_SLEEP;
			rep    = 1'b1;
		end else if (kind <= cnm_pkg::KIND_DEINIT && !st.init) begin
			status = cnm_pkg::STAT_NO_INIT;
		end else begin
			case (kind)
				cnm_pkg::KIND_DEINIT: begin
					n.init = 1'b0;
					n      = cnm_pkg::go_bus_sleep(n);
					rep    = 1'b1;
				end
				cnm_pkg::KIND_REQUEST: begin
					if (net_handle != 8'd0) begin
						status = cnm_pkg::STAT_BAD_HANDLE;
					end else begin
						n.req = 1'b1;
						if (asleep) begin
							n.cbv = st.cbv | cnm_pkg::CBV_ACTIVE_WAKEUP;
							n     = cnm_pkg::go_repeat(n);
							rep   = 1'b1;
						end else if (st.fsm == cnm_pkg::ST_READY_SLEEP) begin
							n   = cnm_pkg::go_normal(n);
							rep = 1'b1;
						end else begin
							n.tmo = '0;
						end
					end
				end
				cnm_pkg::KIND_RELEASE: begin
					if (net_handle != 8'd0) begin
						status = cnm_pkg::STAT_BAD_HANDLE;
					end else begin
						n.req = 1'b0;
						if (st.fsm == cnm_pkg::ST_NORMAL) begin
							n   = cnm_pkg::go_ready(n);
							rep = 1'b1;
						end
					end
				end
				cnm_pkg::KIND_FRAME: begin
					n.tmo = '0;
					if (asleep) begin
						n   = cnm_pkg::go_repeat(n);
						rep = 1'b1;
					end
				end
				cnm_pkg::KIND_TICK: begin
					unique case (st.fsm)
						cnm_pkg::ST_REPEAT: begin
							n.rpt = rpt_inc;
							n.tmo = tmo_inc;
							n.cyc = cyc_hit ? '0 : cyc_inc;
							sent  = cyc_hit && st.tx;
							if (rpt_inc >= cfg.repeat_msg) begin
								n   = st.req ? cnm_pkg::go_normal(n) : cnm_pkg::go_ready(n);
								rep = 1'b1;
							end
						end
						cnm_pkg::ST_NORMAL: begin
							n.tmo = tmo_inc;
							n.cyc = cyc_hit ? '0 : cyc_inc;
							sent  = cyc_hit && st.tx;
							if (tmo_inc >= cfg.nm_timeout) begin
								n   = cnm_pkg::go_repeat(n);
								rep = 1'b1;
							end
						end
						cnm_pkg::ST_READY_SLEEP: begin
							n.tmo = tmo_inc;
							if (tmo_inc >= cfg.nm_timeout) begin
								n   = cnm_pkg::go_prep(n);
								rep = 1'b1;
							end
						end
						cnm_pkg::ST_PREP_SLEEP: begin
							n.slp = slp_inc;
							if (slp_inc >= cfg.wait_sleep) begin
								n   = cnm_pkg::go_bus_sleep(n);
								rep = 1'b1;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	assign st_nxt = n;

	always_comb begin
		res.nm_state    = n.fsm;
		res.mode_report = rep;
		res.send_frame  = sent;
		// A frame goes out with the byte held before any entry on the same tick.
		res.frame_cbv   = sent ? st.cbv : n.cbv;
		res.status      = status;
		unique case (n.fsm)
			cnm_pkg::ST_BUS_SLEEP:  res.nm_mode = cnm_pkg::MODE_BUS_SLEEP;
			cnm_pkg::ST_PREP_SLEEP: res.nm_mode = cnm_pkg::MODE_PREP_SLEEP;
			default:                res.nm_mode = cnm_pkg::MODE_NETWORK;
		endcase
	end

endmodule

[sv/can_network_management_fsm.sv]
// Top level of the CAN network management state machine.
//
//   channel   direction  tdata                     tuser
//   s_axis    in         net_handle [7:0]          kind [2:0]
//   m_axis    out        result word [16:0]        -
//   cfg       in         cfg_wdata, index cfg_idx  -
//
// One word is taken into an input register and processed from there into the result
// register; one word per cycle is sustained while the receiver is ready.
// Reset leaves the block uninitialized in bus sleep with default timings.
// A stalled result holds the input register; the input stalls only when both
// registers are full and the receiver is not ready.
module can_network_management_fsm (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // [7:0] net_handle
	input  logic [2:0]                  s_tuser,  // [2:0] kind
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [2:0] nm_state, [4:3] nm_mode, [5] mode_report, [6] send_frame,
	// [14:7] frame_cbv, [16:15] status, upper bits zero
	output logic [cnm_pkg::DATA_W-1:0]  m_tdata,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_idx,
	input  logic [cnm_pkg::CNT_W-1:0]   cfg_wdata
);

	cnm_pkg::cfg_t   cfg;
	cnm_pkg::nm_st_t st_q;
	cnm_pkg::nm_st_t st_nxt;
	cnm_pkg::res_t   res;
	cnm_pkg::res_t   res_s2;
	logic            vld_s1;
	logic            vld_s2;
	logic [2:0]      kind_s1;
	logic [7:0]      handle_s1;
	logic            adv;

	cnm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	cnm_step u_step (
		.st         (st_q),
		.cfg        (cfg),
		.kind       (kind_s1),
		.net_handle (handle_s1),
		.st_nxt     (st_nxt),
		.res        (res)
	);

	assign adv      = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1   <= s_tuser;
			handle_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{fsm: cnm_pkg::ST_BUS_SLEEP, default: '0};
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {{(cnm_pkg::DATA_W - cnm_pkg::RES_W){1'b0}}, res_s2};

endmodule

[sv/cnm_checker.sv]
// Port-level checker for the CAN network management block, with its bind.
`include "can_network_management_fsm_assert.svh"

module cnm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [cnm_pkg::DATA_W-1:0]  m_tdata
);

	logic [2:0] st;
	logic [1:0] md;
	logic [1:0] stat;
	logic       rep;
	logic       snd;

	assign st   = m_tdata[2:0];
	assign md   = m_tdata[4:3];
	assign rep  = m_tdata[5];
	assign snd  = m_tdata[6];
	assign stat = m_tdata[16:15];

	`CNM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")
	`CNM_ASSERT_IMPLY(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[cnm_pkg::DATA_W-1:cnm_pkg::RES_W] == '0, "padding bits of result word not zero")
	`CNM_ASSERT_IMPLY(a_mode_match, clk, arst_n, m_tvalid, (st == cnm_pkg::ST_BUS_SLEEP && md == cnm_pkg::MODE_BUS_SLEEP) || (st == cnm_pkg::ST_PREP_SLEEP && md == cnm_pkg::MODE_PREP_SLEEP) || ((st == cnm_pkg::ST_READY_SLEEP || st == cnm_pkg::ST_NORMAL || st == cnm_pkg::ST_REPEAT) && md == cnm_pkg::MODE_NETWORK), "mode does not follow state")
	`CNM_ASSERT_IMPLY(a_send_net, clk, arst_n, m_tvalid && snd, stat == cnm_pkg::STAT_OK && md == cnm_pkg::MODE_NETWORK, "frame sent outside network mode")
	`CNM_ASSERT_IMPLY(a_err_quiet, clk, arst_n, m_tvalid && stat != cnm_pkg::STAT_OK, !rep && !snd, "rejected word changed mode or sent a frame")

endmodule

bind can_network_management_fsm cnm_checker u_cnm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[test/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the CAN network management state machine.
module tb_top;
	import cnm_pkg::*;

	localparam int PIPE_LAT = 2;
	localparam int SETTLE = PIPE_LAT + 3;
	localparam int RUN_LIMIT = 400000;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 175;
	localparam int HOLD_CYCLES = 80;
	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;  // [7:0] net_handle
	logic [2:0]           s_tuser = '0;  // [2:0] kind
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// [2:0] nm_state, [4:3] nm_mode, [5] mode_report, [6] send_frame,
	// [14:7] frame_cbv, [16:15] status, upper bits zero
	logic [DATA_W-1:0]    m_tdata;
	logic                 cfg_we = 1'b0;
	logic [1:0]           cfg_idx = '0;
	logic [CNT_W-1:0]     cfg_wdata = '0;
	logic                 hold_kick = 1'b0;

	// Mirror of the block: timings, state and counters.
	logic [CNT_W-1:0]     timing [4];
	bit                   nm_up;
	logic [2:0]           nm_phase;
	bit                   nm_wanted;
	logic [CNT_W-1:0]     silence_ticks;
	logic [CNT_W-1:0]     repeat_ticks;
	logic [CNT_W-1:0]     sleep_ticks;
	logic [CNT_W-1:0]     cycle_ticks;
	bit                   tx_on;
	logic [7:0]           ctrl_bits;
	bit                   entered;

	res_t                 pending_results[$];
	int                   mismatches = 0;
	int unsigned          cycle_no = 0;
	int                   src_idle_pct = 0;
	int                   snk_stall_pct = 0;
	int                   hold_left = 0;
	bit                   hold_done = 1'b0;

	typedef struct {
		bit               is_cfg;
		logic [1:0]       reg_idx;
		logic [CNT_W-1:0] reg_val;
		logic [2:0]       kind;
		logic [7:0]       handle;
		bit               typed;
		res_t             want;
	} step_row_t;

	step_row_t            script[$];

	can_network_management_fsm dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
		if (&v)
			return v;
		return v + 16'd1;
	endfunction

	function automatic void enter_state(logic [2:0] st);
		nm_phase = st;
		entered = 1'b1;
		case (st)
			ST_REPEAT: begin
				repeat_ticks = '0;
				silence_ticks = '0;
				cycle_ticks = '0;
				tx_on = 1'b1;
				ctrl_bits = ctrl_bits | CBV_REPEAT_REQ;
			end
			ST_NORMAL: begin
				silence_ticks = '0;
				tx_on = 1'b1;
				ctrl_bits = ctrl_bits & ~CBV_REPEAT_REQ;
			end
			ST_READY_SLEEP: begin
				silence_ticks = '0;
				tx_on = 1'b0;
			end
			ST_PREP_SLEEP: begin
				sleep_ticks = '0;
				tx_on = 1'b0;
			end
			default: tx_on = 1'b0;
		endcase
	endfunction

	// Advances the message cycle; a frame goes out only while transmission is on.
	function automatic bit msg_due();
		cycle_ticks = bump(cycle_ticks);
		if (cycle_ticks >= timing[CFG_MSG_CYCLE]) begin
			cycle_ticks = '0;
			return tx_on;
		end
		return 1'b0;
	endfunction

	function automatic res_t predict_word(logic [2:0] k, logic [7:0] h);
		res_t       r;
		bit         sent;
		logic [7:0] sent_bits;
		r = '0;
		sent = 1'b0;
		sent_bits = '0;
		entered = 1'b0;
		r.status = STAT_OK;
		if (k == KIND_INIT) begin
			nm_up = 1'b1;
			nm_wanted = 1'b0;
			silence_ticks = '0;
			repeat_ticks = '0;
			sleep_ticks = '0;
			cycle_ticks = '0;
			tx_on = 1'b0;
			ctrl_bits = '0;
			enter_state(ST_BUS_SLEEP);
		end else if (k <= KIND_DEINIT && !nm_up) begin
			r.status = STAT_NO_INIT;
		end else if (k == KIND_DEINIT) begin
			nm_up = 1'b0;
			enter_state(ST_BUS_SLEEP);
		end else if ((k == KIND_REQUEST || k == KIND_RELEASE) && h != 8'd0) begin
			r.status = STAT_BAD_HANDLE;
		end else if (k == KIND_REQUEST) begin
			nm_wanted = 1'b1;
			if (nm_phase == ST_BUS_SLEEP || nm_phase == ST_PREP_SLEEP) begin
				ctrl_bits = ctrl_bits | CBV_ACTIVE_WAKEUP;
				enter_state(ST_REPEAT);
			end else if (nm_phase == ST_READY_SLEEP) begin
				enter_state(ST_NORMAL);
			end else begin
				silence_ticks = '0;
			end
		end else if (k == KIND_RELEASE) begin
			nm_wanted = 1'b0;
			if (nm_phase == ST_NORMAL)
				enter_state(ST_READY_SLEEP);
		end else if (k == KIND_FRAME) begin
			silence_ticks = '0;
			if (nm_phase == ST_BUS_SLEEP || nm_phase == ST_PREP_SLEEP)
				enter_state(ST_REPEAT);
		end else if (k == KIND_TICK) begin
			// The frame carries the control bits from before any entry on this tick.
			case (nm_phase)
				ST_REPEAT: begin
					repeat_ticks = bump(repeat_ticks);
					silence_ticks = bump(silence_ticks);
					sent = msg_due();
					sent_bits = ctrl_bits;
					if (repeat_ticks >= timing[CFG_REPEAT_MSG])
						enter_state(nm_wanted ? ST_NORMAL : ST_READY_SLEEP);
				end
				ST_NORMAL: begin
					silence_ticks = bump(silence_ticks);
					sent = msg_due();
					sent_bits = ctrl_bits;
					if (silence_ticks >= timing[CFG_NM_TIMEOUT])
						enter_state(ST_REPEAT);
				end
				ST_READY_SLEEP: begin
					silence_ticks = bump(silence_ticks);
					if (silence_ticks >= timing[CFG_NM_TIMEOUT])
						enter_state(ST_PREP_SLEEP);
				end
				ST_PREP_SLEEP: begin
					sleep_ticks = bump(sleep_ticks);
					if (sleep_ticks >= timing[CFG_WAIT_SLEEP])
						enter_state(ST_BUS_SLEEP);
				end
				default: ;
			endcase
		end
		r.nm_state = nm_phase;
		if (nm_phase == ST_BUS_SLEEP)
			r.nm_mode = MODE_BUS_SLEEP;
		else if (nm_phase == ST_PREP_SLEEP)
			r.nm_mode = MODE_PREP_SLEEP;
		else
			r.nm_mode = MODE_NETWORK;
		r.mode_report = entered;
		r.send_frame = sent;
		r.frame_cbv = sent ? sent_bits : ctrl_bits;
		return r;
	endfunction

	function automatic res_t mk_res(logic [2:0] st, logic [1:0] md, logic rep, logic snd,
			logic [7:0] cbv, logic [1:0] stat);
		res_t r;
		r.nm_state = st;
		r.nm_mode = md;
		r.mode_report = rep;
		r.send_frame = snd;
		r.frame_cbv = cbv;
		r.status = stat;
		return r;
	endfunction

	function automatic void add_item(logic [2:0] k, logic [7:0] h, bit typed, res_t w);
		step_row_t s;
		s.is_cfg = 1'b0;
		s.reg_idx = '0;
		s.reg_val = '0;
		s.kind = k;
		s.handle = h;
		s.typed = typed;
		s.want = w;
		script.push_back(s);
	endfunction

	function automatic void add_cfg(logic [1:0] idx, logic [CNT_W-1:0] v);
		step_row_t s;
		s.is_cfg = 1'b1;
		s.reg_idx = idx;
		s.reg_val = v;
		s.kind = KIND_TICK;
		s.handle = '0;
		s.typed = 1'b0;
		s.want = '0;
		script.push_back(s);
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch in %s: got 0x%0h, expected 0x%0h (cycle %0d)",
			what, got, want, cycle_no);
		mismatches++;
	endtask

	task automatic send_word(input logic [2:0] k, input logic [7:0] h, input bit typed,
			input res_t typed_want);
		res_t predicted;
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= h;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = predict_word(k, h);
		pending_results.push_back(typed ? typed_want : predicted);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		timing[idx] = v;
	endtask

	always @(posedge clk) begin : drive_ready
		if (hold_kick && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(snk_stall_pct != 0 && $urandom_range(99) < snk_stall_pct);
		end
	end

	always @(posedge clk) begin : watch_results
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[RES_W-1:0]);
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected word", got, 0);
			end else begin
				want = pending_results.pop_front();
				if (got.nm_state != want.nm_state)
					flag_mismatch("nm_state", got.nm_state, want.nm_state);
				if (got.nm_mode != want.nm_mode)
					flag_mismatch("nm_mode", got.nm_mode, want.nm_mode);
				if (got.mode_report != want.mode_report)
					flag_mismatch("mode_report", got.mode_report, want.mode_report);
				if (got.send_frame != want.send_frame)
					flag_mismatch("send_frame", got.send_frame, want.send_frame);
				if (got.frame_cbv != want.frame_cbv)
					flag_mismatch("frame_cbv", got.frame_cbv, want.frame_cbv);
				if (got.status != want.status)
					flag_mismatch("status", got.status, want.status);
				if (m_tdata[DATA_W-1:RES_W] != '0)
					flag_mismatch("padding", m_tdata[DATA_W-1:RES_W], 0);
			end
		end
	end

	always @(posedge clk) begin
		cycle_no++;
		if (cycle_no >= RUN_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin : stimulus
		res_t        no_init;
		res_t        bad_handle;
		res_t        idle_ok;
		res_t        fresh;
		res_t        woken;
		int          counted;
		int unsigned roll;
		logic [2:0]  k;
		logic [7:0]  h;

		timing[CFG_MSG_CYCLE] = RST_MSG_CYCLE;
		timing[CFG_REPEAT_MSG] = RST_REPEAT_MSG;
		timing[CFG_NM_TIMEOUT] = RST_NM_TIMEOUT;
		timing[CFG_WAIT_SLEEP] = RST_WAIT_SLEEP;
		nm_up = 1'b0;
		nm_phase = ST_BUS_SLEEP;
		nm_wanted = 1'b0;
		silence_ticks = '0;
		repeat_ticks = '0;
		sleep_ticks = '0;
		cycle_ticks = '0;
		tx_on = 1'b0;
		ctrl_bits = '0;

		no_init = mk_res(ST_BUS_SLEEP, MODE_BUS_SLEEP, 1'b0, 1'b0, 8'h00, STAT_NO_INIT);
		bad_handle = mk_res(ST_BUS_SLEEP, MODE_BUS_SLEEP, 1'b0, 1'b0, 8'h00, STAT_BAD_HANDLE);
		idle_ok = mk_res(ST_BUS_SLEEP, MODE_BUS_SLEEP, 1'b0, 1'b0, 8'h00, STAT_OK);
		fresh = mk_res(ST_BUS_SLEEP, MODE_BUS_SLEEP, 1'b1, 1'b0, 8'h00, STAT_OK);
		woken = mk_res(ST_REPEAT, MODE_NETWORK, 1'b1, 1'b0,
			CBV_REPEAT_REQ | CBV_ACTIVE_WAKEUP, STAT_OK);

		// Everything before init is refused; then handle checks and the spare kinds.
		add_item(KIND_TICK, 8'h00, 1'b1, no_init);
		add_item(KIND_REQUEST, 8'h00, 1'b1, no_init);
		add_item(KIND_RELEASE, 8'h00, 1'b1, no_init);
		add_item(KIND_FRAME, 8'hFF, 1'b1, no_init);
		add_item(KIND_DEINIT, 8'h00, 1'b1, no_init);
		add_item(KIND_INIT, 8'hAA, 1'b1, fresh);
		add_item(KIND_REQUEST, 8'hFF, 1'b1, bad_handle);
		add_item(KIND_RELEASE, 8'h01, 1'b1, bad_handle);
		add_item(KIND_SPARE_A, 8'h55, 1'b1, idle_ok);
		add_item(KIND_SPARE_B, 8'h00, 1'b1, idle_ok);
		// A zero timeout fires on the first tick.
		add_cfg(CFG_MSG_CYCLE, 16'd1);
		add_cfg(CFG_REPEAT_MSG, 16'd2);
		add_cfg(CFG_NM_TIMEOUT, 16'd0);
		add_cfg(CFG_WAIT_SLEEP, 16'd1);
		add_item(KIND_REQUEST, 8'h00, 1'b1, woken);
		add_item(KIND_TICK, 8'h00, 1'b0, '0);
		add_item(KIND_TICK, 8'h00, 1'b0, '0);
		add_item(KIND_TICK, 8'h00, 1'b0, '0);
		add_item(KIND_RELEASE, 8'h00, 1'b0, '0);
		add_item(KIND_TICK, 8'h00, 1'b0, '0);
		add_item(KIND_TICK, 8'h00, 1'b0, '0);
		add_item(KIND_TICK, 8'h00, 1'b0, '0);
		add_item(KIND_TICK, 8'h00, 1'b0, '0);
		add_item(KIND_FRAME, 8'h00, 1'b0, '0);
		add_item(KIND_DEINIT, 8'h00, 1'b0, '0);
		add_item(KIND_TICK, 8'h00, 1'b0, '0);
		add_item(KIND_INIT, 8'h00, 1'b1, fresh);
		add_cfg(CFG_MSG_CYCLE, 16'hFFFF);
		add_cfg(CFG_REPEAT_MSG, 16'hFFFF);
		add_cfg(CFG_NM_TIMEOUT, 16'hFFFF);
		add_cfg(CFG_WAIT_SLEEP, 16'hFFFF);
		add_item(KIND_REQUEST, 8'h00, 1'b1, woken);
		add_item(KIND_TICK, 8'h00, 1'b0, '0);
		add_item(KIND_FRAME, 8'h00, 1'b0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg)
				write_reg(script[i].reg_idx, script[i].reg_val);
			else
				send_word(script[i].kind, script[i].handle, script[i].typed, script[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1: begin
					write_reg(CFG_MSG_CYCLE, 16'd1);
					write_reg(CFG_REPEAT_MSG, 16'd1);
					write_reg(CFG_NM_TIMEOUT, 16'd1);
					write_reg(CFG_WAIT_SLEEP, 16'd1);
				end
				3: begin
					write_reg(CFG_MSG_CYCLE, 16'hFFFF);
					write_reg(CFG_REPEAT_MSG, 16'($urandom_range(8, 1)));
					write_reg(CFG_NM_TIMEOUT, 16'($urandom_range(10, 1)));
					write_reg(CFG_WAIT_SLEEP, 16'($urandom_range(8, 1)));
				end
				5: begin
					write_reg(CFG_MSG_CYCLE, 16'hFFFF);
					write_reg(CFG_REPEAT_MSG, 16'hFFFF);
					write_reg(CFG_NM_TIMEOUT, 16'hFFFF);
					write_reg(CFG_WAIT_SLEEP, 16'hFFFF);
				end
				default: begin
					write_reg(CFG_MSG_CYCLE, 16'($urandom_range(5, 1)));
					write_reg(CFG_REPEAT_MSG, 16'($urandom_range(8, 1)));
					write_reg(CFG_NM_TIMEOUT, 16'($urandom_range(10, 1)));
					write_reg(CFG_WAIT_SLEEP, 16'($urandom_range(8, 1)));
				end
			endcase
			src_idle_pct = (p % 4 == 1) ? 47 : (p % 4 == 3) ? 28 : 0;
			snk_stall_pct = (p % 4 == 2) ? 47 : (p % 4 == 3) ? 28 : 0;

			// Mostly ticks with requests, releases and frames mixed in; init and
			// deinit are rare so the machine gets deep into its timeouts.
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				roll = $urandom_range(199);
				h = 8'($urandom_range(255));
				if (roll < 120) begin
					k = KIND_TICK;
				end else if (roll < 140) begin
					k = KIND_REQUEST;
					h = 8'h00;
				end else if (roll < 156) begin
					k = KIND_RELEASE;
					h = 8'h00;
				end else if (roll < 174) begin
					k = KIND_FRAME;
				end else if (roll < 177) begin
					k = KIND_INIT;
				end else if (roll < 178) begin
					k = KIND_DEINIT;
				end else if (roll < 192) begin
					k = roll[0] ? KIND_REQUEST : KIND_RELEASE;
					h = 8'($urandom_range(255, 1));
				end else begin
					k = roll[0] ? KIND_SPARE_A : KIND_SPARE_B;
				end
				// Hold off the receiver for a long stretch so the block backs up.
				if (p == 0 && counted == 20)
					hold_kick <= 1'b1;
				if (p == 0 && counted == 21)
					hold_kick <= 1'b0;
				send_word(k, h, 1'b0, '0);
				if (k != KIND_SPARE_A && k != KIND_SPARE_B)
					counted++;
			end
		end

		s_tvalid <= 1'b0;
		for (int w = 0; w < 5000 && pending_results.size() != 0; w++)
			@(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch("results never arrived", pending_results.size(), 0);
		repeat (SETTLE * 4) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[can_network_management_fsm.f]
+incdir+sv
sv/cnm_pkg.sv
sv/cnm_cfg.sv
sv/cnm_step.sv
sv/can_network_management_fsm.sv
sv/cnm_checker.sv
test/tb_top.sv
